// File: design/shbi_pkg.sv
package shbi_pkg;

    localparam logic [4:0]  C_SEED_SHIFT = 5'd5;     // seed 31 = (1 << 5) - 1
    localparam logic [7:0]  C_SLASH      = 8'h2F;
    localparam logic [7:0]  C_TERM       = 8'h00;
    localparam logic [15:0] C_POS_MAX    = 16'hFFFF;

    // One finished key handed from the hashing front to the modulo back end
    typedef struct packed {
        logic [31:0] hash;
        logic        force_zero;   // key_length was zero on the last item
    } t_key_rec;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

// File: design/shbi_front.sv
module shbi_front
    import shbi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_key_byte,
    input  logic [15:0] i_key_length,
    input  logic        i_last,
    input  t_q_status   i_q_status,
    output logic        o_push,
    output t_key_rec    o_rec
);

    logic [31:0] r_acc,     n_acc;
    logic [15:0] r_pos,     n_pos;
    logic        r_stopped, n_stopped;
    logic        stop_hit;
    logic        accept;
    logic [31:0] acc_upd;

    assign o_ready = !i_q_status.full;
    assign accept  = i_valid && o_ready;

    // acc * 31 + byte, wrapping
    assign acc_upd = (r_acc << C_SEED_SHIFT) - r_acc + {24'd0, i_key_byte};

    assign stop_hit = (i_key_byte == C_TERM)
                   || ((i_key_length != 16'd0) && (r_pos == i_key_length - 16'd1)
                       && (i_key_byte == C_SLASH));

    always_comb begin
        n_acc     = r_acc;
        n_pos     = r_pos;
        n_stopped = r_stopped;
        if (!r_stopped) begin
            if (stop_hit) begin
                n_stopped = 1'b1;
            end else begin
                n_acc = acc_upd;
            end
        end
        if (r_pos != C_POS_MAX) begin
            n_pos = r_pos + 16'd1;
        end
    end

    assign o_push           = accept && i_last;
    assign o_rec.hash       = n_acc;
    assign o_rec.force_zero = (i_key_length == 16'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= 32'd0;
            r_pos     <= 16'd0;
            r_stopped <= 1'b0;
        end else if (accept) begin
            if (i_last) begin
                r_acc     <= 32'd0;
                r_pos     <= 16'd0;
                r_stopped <= 1'b0;
            end else begin
                r_acc     <= n_acc;
                r_pos     <= n_pos;
                r_stopped <= n_stopped;
            end
        end
    end

endmodule

// File: design/shbi_fifo.sv
module shbi_fifo
    import shbi_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_key_rec  i_rec,
    input  logic      i_pop,
    output t_key_rec  o_rec,
    output t_q_status o_status
);

    t_key_rec   r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_status.full  = (r_count == 2'd2);
    assign o_status.empty = (r_count == 2'd0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_rec   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) begin
                r_wptr <= ~r_wptr;
            end
            if (do_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= r_count + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("key queue count out of range");

    a_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.full |-> !i_push)
        else $error("key pushed into a full queue");

endmodule

// File: design/shbi_back.sv
module shbi_back
    import shbi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] i_bucket_count,
    input  t_q_status   i_q_status,
    input  t_key_rec    i_rec,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_index
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]  r_state;
    logic [31:0] r_rem;
    logic [31:0] r_dvd;
    logic [31:0] r_div;
    logic [4:0]  r_cnt;
    logic        r_out_valid;
    logic [31:0] r_out;
    logic [32:0] rem_sh;
    logic        sub_ok;
    logic [32:0] rem_sub;
    logic        out_free;

    assign o_pop    = (r_state == ST_IDLE) && !i_q_status.empty;
    assign out_free = !r_out_valid || i_ready;
    assign o_valid  = r_out_valid;
    assign o_index  = r_out;

    // restoring step: one dividend bit per cycle, remainder only
    assign rem_sh  = {r_rem, r_dvd[31]};
    assign sub_ok  = rem_sh >= {1'b0, r_div};
    assign rem_sub = rem_sh - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        r_rem <= 32'd0;
                        r_dvd <= i_rec.hash;
                        r_div <= i_bucket_count;
                        r_cnt <= 5'd31;
                        if (i_rec.force_zero || (i_bucket_count == 32'd0)) begin
                            r_state <= ST_DONE;
                        end else begin
                            r_state <= ST_RUN;
                        end
                    end
                end
                ST_RUN: begin
                    r_rem <= sub_ok ? rem_sub[31:0] : rem_sh[31:0];
                    r_dvd <= {r_dvd[30:0], 1'b0};
                    r_cnt <= r_cnt - 5'd1;
                    if (r_cnt == 5'd0) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_out       <= r_rem;
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |-> (r_rem < r_div))
        else $error("partial remainder not below bucket count");

    a_done_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) |-> ((r_rem < r_div) || (r_rem == 32'd0)))
        else $error("final remainder out of range");

    a_load_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DONE) && out_free) |=> (r_out_valid && (r_out == $past(r_rem))))
        else $error("result register not loaded from divider");

endmodule

// File: design/string_hash_bucket_index_core.sv
// String hash bucket index. Key bytes arrive one item per cycle on s_axis, while the key
// queue is not full, and are folded into a wrapping 32-bit hash (hash * 31 + byte); a zero
// byte, or a '/' at position key_length-1, freezes the hash for the rest of the key. The
// item with tlast set closes the key and queues its hash; a bit-serial restoring divider
// then reduces it modulo bucket_count in 32 divider steps and emits one 32-bit index on
// m_axis, or index 0 when key_length or bucket_count is zero. The divider takes a new
// key only after it has handed off the last one; a two-entry queue lets the next key
// hash while the previous one is reduced. bucket_count is written through i_cfg_we /
// i_cfg_wdata; the user must write it only while the block is idle, as the block itself
// does not enforce it; its reset value is 0 (index 0).
module string_hash_bucket_index_core
    import shbi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [7:0] key_byte, [23:8] key_length
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [31:0] bucket_index
);

    logic [31:0] r_bucket_count;
    logic        push;
    logic        pop;
    t_key_rec    push_rec;
    t_key_rec    head_rec;
    t_q_status   q_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bucket_count <= 32'd0;
        end else if (i_cfg_we) begin
            r_bucket_count <= i_cfg_wdata;
        end
    end

    shbi_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_key_byte   (s_axis_tdata[7:0]),
        .i_key_length (s_axis_tdata[23:8]),
        .i_last       (s_axis_tlast),
        .i_q_status   (q_status),
        .o_push       (push),
        .o_rec        (push_rec)
    );

    shbi_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_rec    (push_rec),
        .i_pop    (pop),
        .o_rec    (head_rec),
        .o_status (q_status)
    );

    shbi_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_bucket_count (r_bucket_count),
        .i_q_status     (q_status),
        .i_rec          (head_rec),
        .o_pop          (pop),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_index        (m_axis_tdata)
    );

endmodule
